// ----- design/ega_row_planar_pixel_decoder_assert.svh -----
// Assertion macros used by the row-planar pixel decoder serializer module.
`ifndef EGA_ROW_PLANAR_PIXEL_DECODER_ASSERT_SVH
`define EGA_ROW_PLANAR_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication under active-low reset.
`define EGARPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egarpd check failed");

// Next-cycle implication under active-low reset.
`define EGARPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egarpd check failed");

`endif

// ----- design/egarpd_pkg.sv -----
// Shared types, plane codes and palette for the row-planar pixel decoder.
package egarpd_pkg;

  // Plane order inside one row
  typedef enum logic [1:0] {
    PLANE_BLUE      = 2'd0,
    PLANE_GREEN     = 2'd1,
    PLANE_RED       = 2'd2,
    PLANE_INTENSITY = 2'd3
  } plane_e;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CfgW    = 4;
  localparam int unsigned PixPerB = 8;
  localparam int unsigned OutDataW = 40;

  // Four plane bytes of one pixel group, handed from the fetch stage
  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] inten;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } ser_ld_t;

  typedef logic [ColorW-1:0] color_t;

  localparam color_t PALETTE [16] = '{
    32'h0000_0000, 32'h0000_A800, 32'h00A8_0000, 32'h00A8_A800,
    32'hA800_0000, 32'hA800_A800, 32'hA854_0000, 32'hA8A8_A800,
    32'h5454_5400, 32'h5454_FE00, 32'h54FE_5400, 32'h54FE_FE00,
    32'hFE54_5400, 32'hFE54_FE00, 32'hFEFE_5400, 32'hFEFE_FEFE
  };

endpackage

// ----- design/egarpd_plane_mem.sv -----
// Row store: one row per byte position, one byte lane per color plane.
module egarpd_plane_mem import egarpd_pkg::*; #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [1:0]         lane_i,
  input  logic [AddrW-1:0]   addr_i,
  input  logic [ByteW-1:0]   wdata_i,
  input  logic               re_i,
  output logic [3*ByteW-1:0] rdata_o
);

  logic [2:0][ByteW-1:0] mem_q [Depth];
  logic [3*ByteW-1:0]    rdata_q;

  // Write one plane lane of a row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i][lane_i] <= wdata_i;
    end
  end

  // Read a whole row, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/egarpd_pixel_ser.sv -----
// Pixel serializer: shifts out eight palette pixels per group through an output register.
module egarpd_pixel_ser import egarpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ser_ld_t             ld_i,
  output logic                ld_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [ColorW-1:0]   color_o,
  output logic [IndexW-1:0]   index_o,
  output logic                last_o
);

  logic             s_busy_q, s_busy_d;
  logic [2:0]       s_cnt_q, s_cnt_d;
  logic [ByteW-1:0] s_blu_q, s_grn_q, s_red_q, s_int_q;
  logic             o_valid_q, o_valid_d;
  color_t           o_color_q;
  logic [IndexW-1:0] o_index_q;
  logic             o_last_q;

  logic              o_free, s_emit, s_fin, ld_take;
  logic [IndexW-1:0] pix_index;

  // Handshake between serializer and output register
  assign o_free    = !o_valid_q || m_ready_i;
  assign s_emit    = s_busy_q && o_free;
  assign s_fin     = s_emit && (s_cnt_q == 3'd7);
  assign ld_ready_o = !s_busy_q || s_fin;
  assign ld_take   = ld_i.vld && ld_ready_o;
  assign pix_index = {s_int_q[ByteW-1], s_red_q[ByteW-1], s_grn_q[ByteW-1], s_blu_q[ByteW-1]};

  // Next serializer and output control state
  always_comb begin
    s_busy_d  = s_busy_q;
    s_cnt_d   = s_cnt_q;
    o_valid_d = o_valid_q;
    if (ld_take) begin
      s_busy_d = 1'b1;
      s_cnt_d  = '0;
    end else if (s_emit) begin
      s_cnt_d = s_cnt_q + 3'd1;
      if (s_fin) begin
        s_busy_d = 1'b0;
      end
    end
    if (s_emit) begin
      o_valid_d = 1'b1;
    end else if (m_ready_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_busy_q  <= 1'b0;
      s_cnt_q   <= '0;
      o_valid_q <= 1'b0;
    end else begin
      s_busy_q  <= s_busy_d;
      s_cnt_q   <= s_cnt_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Load plane bytes or shift the next pixel up to the top bit
  always_ff @(posedge clk_i) begin
    if (ld_take) begin
      s_blu_q <= ld_i.blue;
      s_grn_q <= ld_i.green;
      s_red_q <= ld_i.red;
      s_int_q <= ld_i.inten;
    end else if (s_emit) begin
      s_blu_q <= {s_blu_q[ByteW-2:0], 1'b0};
      s_grn_q <= {s_grn_q[ByteW-2:0], 1'b0};
      s_red_q <= {s_red_q[ByteW-2:0], 1'b0};
      s_int_q <= {s_int_q[ByteW-2:0], 1'b0};
    end
  end

  // Capture the emitted pixel
  always_ff @(posedge clk_i) begin
    if (s_emit) begin
      o_color_q <= PALETTE[pix_index];
      o_index_q <= pix_index;
      o_last_q  <= (s_cnt_q == 3'd7);
    end
  end

  assign m_valid_o = o_valid_q;
  assign color_o   = o_color_q;
  assign index_o   = o_index_q;
  assign last_o    = o_last_q;

  `include "ega_row_planar_pixel_decoder_assert.svh"

  `EGARPD_ASSERT_NOW(a_no_overrun, clk_i, rst_ni, ld_take, (!s_busy_q || s_fin))
  `EGARPD_ASSERT_NEXT(a_last_on_eighth, clk_i, rst_ni, s_fin, (o_valid_q && o_last_q))
  `EGARPD_ASSERT_NOW(a_color_matches, clk_i, rst_ni, o_valid_q, (o_color_q == PALETTE[o_index_q]))

endmodule

// ----- design/ega_row_planar_pixel_decoder.sv -----
// Top level: row-planar byte stream in, palette pixel words out.
//
//  channel   dir  word content
//  s_axis    in   tdata[7:0] data_byte
//  m_axis    out  tdata[31:0] pixel_color, [35:32] palette_index; tlast last_of_run
//  cfg       in   cfg_data_i[3:0] plane_bytes
//
// Blue, green and red bytes only write the row store.
// An intensity byte reads its row into a registered output, then yields eight pixels,
// one per cycle while m_axis accepts them.
// There is a single serializer; one intensity byte waits in the fetch stage.
// Reset clears position, plane and valid flags and sets plane_bytes to 2; the row store is not cleared.
// A stalled m_axis holds the pixel and backs up into s_axis_tready.
module ega_row_planar_pixel_decoder import egarpd_pkg::*; #(
  parameter int unsigned MAX_PLANE_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [31:0] pixel_color, [35:32] palette_index
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i      // [3:0] plane_bytes
);

  localparam int unsigned PosW = (MAX_PLANE_BYTES > 1) ? $clog2(MAX_PLANE_BYTES) : 1;
  localparam int unsigned CntW = PosW + 1;
  localparam int unsigned CmpW = (CntW > CfgW) ? CntW : CfgW;

  logic [CfgW-1:0] plane_bytes_q;
  logic [PosW-1:0] pos_q, pos_d;
  plane_e          plane_q, plane_d;
  logic            a_valid_q, a_valid_d;
  logic [ByteW-1:0] a_int_q;

  logic            accept, is_int, row_end, ld_ready;
  logic [CmpW-1:0] pos_inc;
  logic [3*ByteW-1:0] row_data;
  ser_ld_t         ld;
  color_t          color;
  logic [IndexW-1:0] index;

  // Config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_bytes_q <= CfgW'(2);
    end else if (cfg_valid_i) begin
      plane_bytes_q <= cfg_data_i;
    end
  end

  // Input handshake and plane decode
  assign s_axis_tready = !a_valid_q || ld_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_int        = (plane_q == PLANE_INTENSITY);

  // End of plane: position reaches the clamped width
  assign pos_inc = CmpW'(pos_q) + CmpW'(1);
  assign row_end = (pos_inc >= CmpW'(plane_bytes_q)) || (pos_inc >= CmpW'(MAX_PLANE_BYTES));

  // Advance position and plane per accepted word
  always_comb begin
    pos_d   = pos_q;
    plane_d = plane_q;
    if (accept) begin
      if (row_end) begin
        pos_d   = '0;
        plane_d = plane_e'(plane_q + 2'd1);
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Fetch stage holds one intensity byte until the serializer takes it
  always_comb begin
    a_valid_d = a_valid_q;
    if (accept && is_int) begin
      a_valid_d = 1'b1;
    end else if (ld_ready) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      plane_q   <= PLANE_BLUE;
      a_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      plane_q   <= plane_d;
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_int) begin
      a_int_q <= s_axis_tdata;
    end
  end

  egarpd_plane_mem #(
    .Depth (MAX_PLANE_BYTES),
    .AddrW (PosW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (accept && !is_int),
    .lane_i  (plane_q),
    .addr_i  (pos_q),
    .wdata_i (s_axis_tdata),
    .re_i    (accept && is_int),
    .rdata_o (row_data)
  );

  // Hand the four plane bytes to the serializer
  always_comb begin
    ld.vld   = a_valid_q;
    ld.inten = a_int_q;
    ld.red   = row_data[3*ByteW-1:2*ByteW];
    ld.green = row_data[2*ByteW-1:ByteW];
    ld.blue  = row_data[ByteW-1:0];
  end

  egarpd_pixel_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (ld),
    .ld_ready_o (ld_ready),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .color_o    (color),
    .index_o    (index),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {(OutDataW - ColorW - IndexW)'(0), index, color};

endmodule
